// ===== sv/dhsv_pkg.sv =====
// ----------------------------------------------------------------------------
// dhsv_pkg
// Shared widths, constants and config register codes for the distance to
// HSV LED color mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package dhsv_pkg;

  // grid geometry
  localparam int ZONES_PER_ROW = 8;
  localparam int ZONE_COUNT    = 64;
  localparam int COLUMN_BASE   = 2;

  // field widths
  localparam int ZONE_W   = 6;
  localparam int STATUS_W = 8;
  localparam int DIST_W   = 12;
  localparam int COL_W    = 4;
  localparam int ROW_W    = 3;
  localparam int CHAN_W   = 8;

  // config registers
  localparam int SAT_W    = 9;
  localparam int VAL_W    = 9;
  localparam int CUTOFF_W = 11;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SATURATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF     = 2'd2;

  localparam logic [SAT_W-1:0]    SAT_RESET    = 9'd256;
  localparam logic [VAL_W-1:0]    VAL_RESET    = 9'd256;
  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 11'd1000;

  localparam logic [STATUS_W-1:0] NO_TARGET  = 8'd255;
  localparam logic [CHAN_W-1:0]   GRAY_LEVEL = 8'd150;

  // hue = floor(d*3/20) + 10 ; /20 done as (x>>2) * 52429 >> 18
  localparam int HUE_W      = 9;
  localparam int HUE_RECIP  = 52429;
  localparam int HUE_SHIFT  = 18;
  localparam int HUE_BASE   = 10;

  // sector = hue / 60 via hue * 1093 >> 16
  localparam int SECTOR_DEG   = 60;
  localparam int SECTOR_RECIP = 1093;
  localparam int SECTOR_SHIFT = 16;
  localparam int SECTOR_W     = 3;
  localparam int REM_W        = 6;
  localparam int K_W          = 7;

  // component = V*(15360 - S*k), channel = floor(num*17 / 2^18)
  localparam int FULL_SCALE  = 15360;
  localparam int FACTOR_W    = 14;
  localparam int PROD_W      = 23;
  localparam int CHAN_MUL    = 17;
  localparam int CHAN_SHIFT  = 18;

  typedef struct packed {
    logic factor;   // load the S*k factor stage
    logic product;  // load the V*factor stage
  } chan_en_t;

endpackage

`default_nettype wire

// ===== sv/dhsv_if.sv =====
// ----------------------------------------------------------------------------
// dhsv_if
// Valid/ready channels for ranging targets and LED pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface dhsv_target_if;
  import dhsv_pkg::*;
  logic                valid;
  logic                ready;
  logic [ZONE_W-1:0]   zone;
  logic [STATUS_W-1:0] status;
  logic [DIST_W-1:0]   distance;

  modport source (output valid, zone, status, distance, input ready);
  modport sink   (input valid, zone, status, distance, output ready);
endinterface

interface dhsv_pixel_if;
  import dhsv_pkg::*;
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  pixel_column;
  logic [ROW_W-1:0]  pixel_row;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, pixel_column, pixel_row, red, green, blue,
                  input ready);
  modport sink   (input valid, pixel_column, pixel_row, red, green, blue,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/dhsv_chan.sv =====
// ----------------------------------------------------------------------------
// dhsv_chan
// One HSV component: factor 15360 - S*k, product with V, then scale to 0..255.
// Two register stages; the scaled value is combinational off the product.
// ----------------------------------------------------------------------------
`default_nettype none

module dhsv_chan (
  input  wire logic                      clk,
  input  wire dhsv_pkg::chan_en_t        en,
  input  wire logic [dhsv_pkg::K_W-1:0]  k,
  input  wire logic [dhsv_pkg::SAT_W-1:0] sat,
  input  wire logic [dhsv_pkg::VAL_W-1:0] val,
  output logic [dhsv_pkg::CHAN_W-1:0]    chan
);
  import dhsv_pkg::*;

  localparam int SK_W = SAT_W + K_W;
  localparam int SC_W = PROD_W + 5;

  logic [SK_W-1:0]     sk;
  logic                f_pos;
  logic [FACTOR_W-1:0] factor;
  logic [PROD_W-1:0]   prod;
  logic [SC_W-1:0]     scaled;
  logic [SC_W-CHAN_SHIFT-1:0] level;

  assign sk = SK_W'(sat) * SK_W'(k);

  always_ff @(posedge clk) begin
    if (en.factor) begin
      f_pos  <= sk < SK_W'(FULL_SCALE);
      factor <= FACTOR_W'(SK_W'(FULL_SCALE) - sk);
    end
    if (en.product) begin
      // non-positive component clamps to zero
      prod <= f_pos ? PROD_W'(PROD_W'(val) * PROD_W'(factor)) : '0;
    end
  end

  assign scaled = SC_W'(prod) * SC_W'(CHAN_MUL);
  assign level  = scaled[SC_W-1:CHAN_SHIFT];
  assign chan   = (level > (SC_W-CHAN_SHIFT)'(255)) ? '1 : level[CHAN_W-1:0];

endmodule

`default_nettype wire

// ===== sv/distance_to_hsv_led_color.sv =====
// ----------------------------------------------------------------------------
// distance_to_hsv_led_color
// Maps one ranging target to one LED pixel: grid position from the zone,
// color from a distance-driven hue through a six-sector HSV-to-RGB step.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  target    in   valid/ready    zone, status, distance
//  pixel     out  valid/ready    pixel_column, pixel_row, red, green, blue
//  cfg       in   cfg_we         cfg_index, cfg_data (no read-back)
//
//  Six register stages, one transfer per cycle sustained while pixel.ready
//  stays high; a target passes v1..v5 and the output register to the pixel.
//  Stage depth is set by the multipliers: hue reciprocal, sector reciprocal,
//  S*k, then V*factor, each with a register behind it.
//  Each full stage holds when its successor is full and stalled, so backpressure
//  ripples back to target.ready without losing or repeating an item.
//  rst (synchronous) clears all stage valid bits and loads register defaults;
//  target.ready is low while rst is high.
//
`default_nettype none

module distance_to_hsv_led_color (
  input  wire logic                          clk,
  input  wire logic                          rst,
  dhsv_target_if.sink                        target,
  dhsv_pixel_if.source                       pixel,
  input  wire logic                          cfg_we,
  input  wire logic [dhsv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dhsv_pkg::CFG_W-1:0]    cfg_data
);
  import dhsv_pkg::*;

  localparam int HX_W    = CUTOFF_W + 2;          // d*3
  localparam int HY_W    = HX_W - 2;              // (d*3)>>2
  localparam int HP_W    = HY_W + 16;             // times reciprocal
  localparam int SP_W    = HUE_W + 11;            // hue * sector reciprocal
  localparam int ZEXT_W  = ZONE_W + 1;

  // ---------------- config registers ----------------
  logic [SAT_W-1:0]    saturation;
  logic [VAL_W-1:0]    brightness_value;
  logic [CUTOFF_W-1:0] cutoff_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation       <= SAT_RESET;
      brightness_value <= VAL_RESET;
      cutoff_distance  <= CUTOFF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SATURATION: saturation       <= cfg_data[SAT_W-1:0];
        CFG_BRIGHTNESS: brightness_value <= cfg_data[VAL_W-1:0];
        CFG_CUTOFF:     cutoff_distance  <= cfg_data[CUTOFF_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // v1..v5 are internal stages; the pixel output register is stage six.
  logic v1, v2, v3, v4, v5, ov;
  logic adv1, adv2, adv3, adv4, adv5, adv_out;

  assign adv_out = !ov || pixel.ready;
  assign adv5    = !v5 || adv_out;
  assign adv4    = !v4 || adv5;
  assign adv3    = !v3 || adv4;
  assign adv2    = !v2 || adv3;
  assign adv1    = !v1 || adv2;

  assign target.ready = adv1 && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (adv1)    v1 <= target.valid;
      if (adv2)    v2 <= v1;
      if (adv3)    v3 <= v2;
      if (adv4)    v4 <= v3;
      if (adv5)    v5 <= v4;
      if (adv_out) ov <= v5;
    end
  end

  // ---------------- stage 1: position, gray flag, cutoff ----------------
  logic [ZEXT_W-1:0]   zone_w;
  logic [COL_W-1:0]    col1, col2, col3, col4, col5;
  logic [ROW_W-1:0]    row1, row2, row3, row4, row5;
  logic                gray1, gray2, gray3, gray4, gray5;
  logic [CUTOFF_W-1:0] d1;

  assign zone_w = ZEXT_W'(target.zone) % ZEXT_W'(ZONE_COUNT);

  always_ff @(posedge clk) begin
    if (adv1) begin
      col1  <= COL_W'(zone_w / ZEXT_W'(ZONES_PER_ROW) + ZEXT_W'(COLUMN_BASE));
      row1  <= ROW_W'(zone_w % ZEXT_W'(ZONES_PER_ROW));
      gray1 <= target.status == NO_TARGET;
      // far targets read as distance zero
      d1    <= (target.distance > DIST_W'(cutoff_distance))
               ? '0 : target.distance[CUTOFF_W-1:0];
    end
  end

  // ---------------- stage 2: hue ----------------
  logic [HX_W-1:0]  hx;
  logic [HP_W-1:0]  hp;
  logic [HUE_W-1:0] hue2;

  assign hx = HX_W'(d1) * HX_W'(3);
  assign hp = HP_W'(hx[HX_W-1:2]) * HP_W'(HUE_RECIP);

  always_ff @(posedge clk) begin
    if (adv2) begin
      hue2  <= HUE_W'(hp[HP_W-1:HUE_SHIFT]) + HUE_W'(HUE_BASE);
      col2  <= col1;
      row2  <= row1;
      gray2 <= gray1;
    end
  end

  // ---------------- stage 3: sector and remainder ----------------
  logic [SP_W-1:0]     sp;
  logic [SECTOR_W-1:0] sec_c, sec3, sec4, sec5;
  logic [HUE_W-1:0]    sec_deg;
  logic [REM_W-1:0]    rem3;

  assign sp      = SP_W'(hue2) * SP_W'(SECTOR_RECIP);
  assign sec_c   = SECTOR_W'(sp[SP_W-1:SECTOR_SHIFT]);
  assign sec_deg = HUE_W'(sec_c) * HUE_W'(SECTOR_DEG);

  always_ff @(posedge clk) begin
    if (adv3) begin
      sec3  <= sec_c;
      rem3  <= REM_W'(hue2 - sec_deg);
      col3  <= col2;
      row3  <= row2;
      gray3 <= gray2;
    end
  end

  // ---------------- stages 4/5: component datapaths ----------------
  chan_en_t         chan_en;
  logic [K_W-1:0]   k_q, k_t;
  logic [CHAN_W-1:0] ch_full, ch_p, ch_q, ch_t;

  assign chan_en.factor  = adv4;
  assign chan_en.product = adv5;
  assign k_q = K_W'(rem3);
  assign k_t = K_W'(SECTOR_DEG) - K_W'(rem3);

  dhsv_chan u_full (.clk, .en(chan_en), .k(K_W'(0)), .sat(saturation),
                    .val(brightness_value), .chan(ch_full));
  dhsv_chan u_p    (.clk, .en(chan_en), .k(K_W'(SECTOR_DEG)), .sat(saturation),
                    .val(brightness_value), .chan(ch_p));
  dhsv_chan u_q    (.clk, .en(chan_en), .k(k_q), .sat(saturation),
                    .val(brightness_value), .chan(ch_q));
  dhsv_chan u_t    (.clk, .en(chan_en), .k(k_t), .sat(saturation),
                    .val(brightness_value), .chan(ch_t));

  always_ff @(posedge clk) begin
    if (adv4) begin
      sec4  <= sec3;
      col4  <= col3;
      row4  <= row3;
      gray4 <= gray3;
    end
    if (adv5) begin
      sec5  <= sec4;
      col5  <= col4;
      row5  <= row4;
      gray5 <= gray4;
    end
  end

  // ---------------- stage 6: sector select, output register ----------------
  logic [CHAN_W-1:0] r_c, g_c, b_c;

  always_comb begin
    case (sec5)
      3'd0:    begin r_c = ch_full; g_c = ch_t;    b_c = ch_p;    end
      3'd1:    begin r_c = ch_q;    g_c = ch_full; b_c = ch_p;    end
      3'd2:    begin r_c = ch_p;    g_c = ch_full; b_c = ch_t;    end
      3'd3:    begin r_c = ch_p;    g_c = ch_q;    b_c = ch_full; end
      3'd4:    begin r_c = ch_t;    g_c = ch_p;    b_c = ch_full; end
      3'd5:    begin r_c = ch_full; g_c = ch_p;    b_c = ch_q;    end
      default: begin r_c = '0;      g_c = '0;      b_c = '0;      end  // hue >= 360
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      pixel.pixel_column <= col5;
      pixel.pixel_row    <= row5;
      pixel.red          <= gray5 ? GRAY_LEVEL : r_c;
      pixel.green        <= gray5 ? GRAY_LEVEL : g_c;
      pixel.blue         <= gray5 ? GRAY_LEVEL : b_c;
    end
  end

  assign pixel.valid = ov;

endmodule

`default_nettype wire

// ===== sv/dhsv_checker.sv =====
// ----------------------------------------------------------------------------
// dhsv_checker
// Port-level checks on the pixel mapper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dhsv_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          pixel_valid,
  input wire logic                          pixel_ready,
  input wire logic [dhsv_pkg::COL_W-1:0]    pixel_column,
  input wire logic [dhsv_pkg::ROW_W-1:0]    pixel_row,
  input wire logic [dhsv_pkg::CHAN_W-1:0]   red,
  input wire logic [dhsv_pkg::CHAN_W-1:0]   green,
  input wire logic [dhsv_pkg::CHAN_W-1:0]   blue
);
  import dhsv_pkg::*;

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !pixel_valid)
    else $error("pixel valid right after reset");

  // column stays in 2..9 (zone/8 + 2 over the whole grid)
  a_column_range: assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> (pixel_column >= COL_W'(COLUMN_BASE)) &&
                    (pixel_column <= COL_W'(COLUMN_BASE + ZONE_COUNT / ZONES_PER_ROW - 1)))
    else $error("pixel column out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_ready |=> pixel_valid)
    else $error("pixel valid dropped while stalled");

  a_stall_stable: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_ready |=>
      $stable(pixel_column) && $stable(pixel_row) && $stable(red) &&
      $stable(green) && $stable(blue))
    else $error("pixel payload changed while stalled");

endmodule

bind distance_to_hsv_led_color dhsv_checker u_dhsv_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_valid  (pixel.valid),
  .pixel_ready  (pixel.ready),
  .pixel_column (pixel.pixel_column),
  .pixel_row    (pixel.pixel_row),
  .red          (pixel.red),
  .green        (pixel.green),
  .blue         (pixel.blue)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the distance to HSV LED color mapper. A clocked driver sends ranging
// targets from a queue, a built-in color predictor works out each pixel, and
// a clocked monitor compares every pixel transfer field by field. Both sides
// idle at random, and the color registers are changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import dhsv_pkg::*;

  // run control
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 12;    // drain margin; pipeline is six deep
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 50;
  localparam int MAX_WAIT = 16;

  // color math: channel = floor(255 * V*(15360 - S*k) / 3932160)
  localparam longint CHAN_MAX   = 255;
  localparam longint COMP_DENOM = 3932160;
  localparam int     HUE_SPAN   = 300;
  localparam int     HUE_DIST   = 2000;
  localparam int     DIST_MAX   = 4095;
  localparam int     CUTOFF_MAX = 2047;
  localparam int     SAT_MAX    = 511;
  localparam int     UNIT_Q8    = 256;

  // register index that does not exist; the block must ignore the write
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [ZONE_W-1:0]   zone;
    logic [STATUS_W-1:0] status;
    logic [DIST_W-1:0]   distance;
  } target_t;

  typedef struct packed {
    logic [COL_W-1:0]  pixel_column;
    logic [ROW_W-1:0]  pixel_row;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  dhsv_target_if target_bus ();
  dhsv_pixel_if  pixel_bus ();

  distance_to_hsv_led_color DUT (
    .clk       (clk),
    .rst       (rst),
    .target    (target_bus),
    .pixel     (pixel_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor's copy of the color registers
  logic [SAT_W-1:0]    sat_q8;
  logic [VAL_W-1:0]    value_q8;
  logic [CUTOFF_W-1:0] cutoff_mm;

  target_t pending_targets[$];   // not yet offered to the block
  pixel_t  pixel_expected[$];    // predicted pixels, oldest first

  bit failed;
  bit send_calm;                 // sender stretch with no idle cycles
  bit recv_calm;                 // receiver stretch with no stall cycles
  int send_wait;
  int recv_wait;
  int cycle_count;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Color predictor
  // --------------------------------------------------------------------------

  // One channel for the sector offset k (0 = full value, 60 = p, r = q,
  // 60 - r = t). Oversaturation drives the numerator negative -> 0, a value
  // above 1.0 can overshoot -> clamp to 255.
  function automatic logic [CHAN_W-1:0] channel_level(input int k);
    longint num;
    longint level;
    num = longint'(value_q8) * (longint'(FULL_SCALE) - longint'(sat_q8) * k);
    if (num <= 0)
      return '0;
    level = num * CHAN_MAX / COMP_DENOM;
    if (level > CHAN_MAX)
      level = CHAN_MAX;
    return level[CHAN_W-1:0];
  endfunction

  function automatic pixel_t predict_pixel(input target_t t);
    pixel_t px;
    int zone_n;
    int dist_mm;
    int hue;
    int sector;
    int rem;
    logic [CHAN_W-1:0] full, pk, qk, tk;
    zone_n = int'(t.zone) % ZONE_COUNT;
    px.pixel_column = COL_W'(zone_n / ZONES_PER_ROW + COLUMN_BASE);
    px.pixel_row    = ROW_W'(zone_n % ZONES_PER_ROW);
    if (t.status == NO_TARGET) begin
      px.red   = GRAY_LEVEL;
      px.green = GRAY_LEVEL;
      px.blue  = GRAY_LEVEL;
      return px;
    end
    // far targets fold back to distance zero
    dist_mm = (int'(t.distance) > int'(cutoff_mm)) ? 0 : int'(t.distance);
    hue = dist_mm * HUE_SPAN / HUE_DIST + HUE_BASE;
    sector = hue / SECTOR_DEG;
    rem = hue % SECTOR_DEG;
    full = channel_level(0);
    pk = channel_level(SECTOR_DEG);
    qk = channel_level(rem);
    tk = channel_level(SECTOR_DEG - rem);
    case (sector)
      0: begin px.red = full; px.green = tk;   px.blue = pk;   end
      1: begin px.red = qk;   px.green = full; px.blue = pk;   end
      2: begin px.red = pk;   px.green = full; px.blue = tk;   end
      3: begin px.red = pk;   px.green = qk;   px.blue = full; end
      4: begin px.red = tk;   px.green = pk;   px.blue = full; end
      5: begin px.red = full; px.green = pk;   px.blue = qk;   end
      default: begin
        // hue past 360: black (cannot come out of the cutoff bound)
        px.red = '0; px.green = '0; px.blue = '0;
      end
    endcase
    return px;
  endfunction

  // idle/stall cycles before the next transfer on one side
  function automatic int draw_wait(input bit calm);
    if (calm || $urandom_range(0, 2) == 0)
      return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // --------------------------------------------------------------------------
  // Target driver: offers queued targets, predicts at each accepted transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : target_driver
    target_t shown;
    target_t nxt;
    if (rst) begin
      target_bus.valid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (target_bus.valid && target_bus.ready) begin
        shown.zone     = target_bus.zone;
        shown.status   = target_bus.status;
        shown.distance = target_bus.distance;
        pixel_expected.push_back(predict_pixel(shown));
      end
      // bus is free when nothing is offered or the offer just went through
      if (!target_bus.valid || target_bus.ready) begin
        if (send_wait != 0) begin
          target_bus.valid <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (pending_targets.size() != 0) begin
          nxt = pending_targets.pop_front();
          target_bus.valid    <= 1'b1;
          target_bus.zone     <= nxt.zone;
          target_bus.status   <= nxt.status;
          target_bus.distance <= nxt.distance;
          send_wait <= draw_wait(send_calm);
        end else begin
          target_bus.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pixel monitor: checks each transfer, then stalls ready at random
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [CHAN_W-1:0] want,
                             input logic [CHAN_W-1:0] got);
    if (got !== want) begin
      $display("%0t pixel %s mismatch: expected %0d actual %0d", $time, name,
               want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin : pixel_monitor
    int stall;
    pixel_t want;
    if (rst) begin
      pixel_bus.ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      stall = recv_wait;
      if (pixel_bus.valid && pixel_bus.ready) begin
        if (pixel_expected.size() == 0) begin
          $display("%0t pixel with none expected: expected nothing actual %0d,%0d %0d/%0d/%0d",
                   $time, pixel_bus.pixel_column, pixel_bus.pixel_row,
                   pixel_bus.red, pixel_bus.green, pixel_bus.blue);
          failed = 1'b1;
        end else begin
          want = pixel_expected.pop_front();
          check_field("column", CHAN_W'(want.pixel_column),
                      CHAN_W'(pixel_bus.pixel_column));
          check_field("row", CHAN_W'(want.pixel_row), CHAN_W'(pixel_bus.pixel_row));
          check_field("red", want.red, pixel_bus.red);
          check_field("green", want.green, pixel_bus.green);
          check_field("blue", want.blue, pixel_bus.blue);
        end
        stall = draw_wait(recv_calm);
      end
      if (stall != 0) begin
        pixel_bus.ready <= 1'b0;
        recv_wait <= stall - 1;
      end else begin
        pixel_bus.ready <= 1'b1;
        recv_wait <= 0;
      end
    end
  end

  // hard stop for a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // register write; the caller changes color rules only while idle, the block does not enforce it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_SATURATION: sat_q8    = data[SAT_W-1:0];
      CFG_BRIGHTNESS: value_q8  = data[VAL_W-1:0];
      CFG_CUTOFF:     cutoff_mm = data[CUTOFF_W-1:0];
      default: ;  // unused index: ignored
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_target(input int zone, input int status, input int dist_mm);
    target_t t;
    t.zone     = ZONE_W'(zone);
    t.status   = STATUS_W'(status);
    t.distance = DIST_W'(dist_mm);
    pending_targets.push_back(t);
  endtask

  // everything offered, accepted and checked, then let the pipe drain
  task automatic wait_idle();
    while (pending_targets.size() != 0 || pixel_expected.size() != 0 ||
           target_bus.valid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_q8();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return UNIT_Q8;
      2: return SAT_MAX;
      3, 4: return $urandom_range(0, UNIT_Q8);
      default: return $urandom_range(UNIT_Q8 + 1, SAT_MAX);
    endcase
  endfunction

  function automatic int pick_cutoff();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return HUE_DIST;
      2: return CUTOFF_MAX;
      default: return $urandom_range(0, CUTOFF_MAX);
    endcase
  endfunction

  initial begin
    // known values on every input before the first edge
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    target_bus.valid = 1'b0;
    target_bus.zone = '0;
    target_bus.status = '0;
    target_bus.distance = '0;
    pixel_bus.ready = 1'b0;
    cycle_count = 0;
    failed = 1'b0;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    sat_q8 = SAT_RESET;
    value_q8 = VAL_RESET;
    cutoff_mm = CUTOFF_RESET;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // -- directed, reset registers: sectors 0..2, gray, cutoff edge
    push_target(0, 0, 0);            // lowest hue
    push_target(63, NO_TARGET, DIST_MAX);
    push_target(7, 254, 1000);       // exactly at cutoff
    push_target(56, 1, 1001);        // just past cutoff -> distance 0
    push_target(8, 0, 334);          // hue 60
    push_target(9, 0, 734);          // hue 120
    push_target(42, 128, DIST_MAX);
    wait_idle();

    // -- widest cutoff reaches sectors 3..5; value above 1.0 saturates
    write_reg(CFG_CUTOFF, 11'h7FF);
    write_reg(CFG_BRIGHTNESS, 11'h1FF);
    write_reg(CFG_UNUSED, 11'h7FF);  // must not touch anything
    push_target(17, 0, 1134);        // hue 180
    push_target(26, 0, 1534);        // hue 240
    push_target(35, 0, 1934);        // hue 300
    push_target(44, 0, CUTOFF_MAX);  // highest hue
    push_target(53, 0, CUTOFF_MAX + 1);
    push_target(62, 0, 0);
    wait_idle();

    // -- oversaturation: negative components clamp to zero
    write_reg(CFG_SATURATION, 11'h7FF);  // upper bits masked off
    write_reg(CFG_BRIGHTNESS, 11'(UNIT_Q8));
    push_target(1, 0, 500);
    push_target(2, 0, 1234);
    push_target(3, 0, 1800);
    push_target(4, NO_TARGET, 0);
    wait_idle();

    // -- zero saturation and zero value: black
    write_reg(CFG_SATURATION, 11'h600);  // masks to 0
    write_reg(CFG_BRIGHTNESS, 11'h000);
    write_reg(CFG_CUTOFF, 11'h000);
    push_target(31, 0, 0);
    push_target(32, 77, 1);
    push_target(39, 0, DIST_MAX);
    wait_idle();

    // -- random phases, fresh registers and idle style each time
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_reg(CFG_SATURATION, {CFG_W'($urandom_range(0, 3)) << SAT_W} |
                                CFG_W'(pick_q8()));
      write_reg(CFG_BRIGHTNESS, {CFG_W'($urandom_range(0, 3)) << VAL_W} |
                                CFG_W'(pick_q8()));
      write_reg(CFG_CUTOFF, CFG_W'(pick_cutoff()));
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_UNUSED, CFG_W'($urandom));
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // mostly targets inside the cutoff so the hue actually moves
        push_target($urandom_range(0, ZONE_COUNT - 1),
                    ($urandom_range(0, 7) == 0) ? int'(NO_TARGET)
                                                : $urandom_range(0, 255),
                    ($urandom_range(0, 3) != 0) ? $urandom_range(0, cutoff_mm)
                                                : $urandom_range(0, DIST_MAX));
      end
      wait_idle();
    end

    if (!failed && pixel_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
